FILE: design/top_k_smallest_tracker_macros.svh
// Assertion macros shared by the top-k tracker RTL.
`ifndef TOP_K_SMALLEST_TRACKER_MACROS_SVH
`define TOP_K_SMALLEST_TRACKER_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TKST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence on the next clock edge.
`define TKST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tkst_pkg.sv
// Shared constants and payload types of the top-k tracker.
package tkst_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int KEEP_W      = ADDR_W + 1;
    localparam int SCORE_W     = 32;
    localparam int TAG_W       = 32;

    localparam logic [KEEP_W-1:0] DEPTH_COUNT = KEEP_W'(STORE_DEPTH);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
        logic [ADDR_W-1:0]         rank;
    } in_t;

    typedef struct packed {
        logic                      accepted;
        logic [ADDR_W-1:0]         slot;
        logic [ADDR_W-1:0]         position;
        logic signed [SCORE_W-1:0] out_score;
        logic [TAG_W-1:0]          out_tag;
        logic                      entry_valid;
    } out_t;

endpackage

FILE: design/top_k_smallest_tracker.sv
// Top-k smallest score tracker: slot store, rank list and insertion sequencer.
//
// Usage:
//   Commands arrive on the input channel (in_valid / in_stall / in_data); one
//   result per command leaves on the output channel (out_valid / out_stall /
//   out_data). in_stall is high while a command is being worked on.
//   keep_count is written through cfg_we / cfg_wdata while the block is idle.
// Latency (accepting edge to the first edge at which the result can transfer):
//   clear, out-of-range read or unknown command: 2; read of a filled rank: 5
//   insert: 3 into an empty list, 6 + k while not full, 9 + k once full, one
//   less when the score moves up to rank 0; full-list reject 5, keep_count 1: 6.
//   k is the number of worse entries moved down one rank (at most keep_count - 1);
//   the rank walk reads one entry a cycle through a single signed comparator.
// Throughput: one command at a time; the next is taken once the result has
//   been handed to the output register.
// Reset clears the fill count, sets keep_count to 1024 and empties the output
//   register; the slot and rank stores keep their contents.
// A stalled receiver holds the result in the output register; a finished
//   command waits in the sequencer until that register is free.
`include "top_k_smallest_tracker_macros.svh"

module top_k_smallest_tracker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  tkst_pkg::in_t                         in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output tkst_pkg::out_t                        out_data,
    input  logic                                  cfg_we,
    input  logic [tkst_pkg::KEEP_W-1:0]           cfg_wdata
);

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_WORST1    = 12'b0000_0000_0010,
        ST_WORST2    = 12'b0000_0000_0100,
        ST_WORST_CMP = 12'b0000_0000_1000,
        ST_SHIFT1    = 12'b0000_0001_0000,
        ST_SHIFT2    = 12'b0000_0010_0000,
        ST_SHIFT     = 12'b0000_0100_0000,
        ST_PLACE     = 12'b0000_1000_0000,
        ST_READ1     = 12'b0001_0000_0000,
        ST_READ2     = 12'b0010_0000_0000,
        ST_READ_OUT  = 12'b0100_0000_0000,
        ST_RESP      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [tkst_pkg::ADDR_W-1:0]  pos_reg, pos_next;
    logic [tkst_pkg::ADDR_W-1:0]  iss_reg, iss_next;
    logic [tkst_pkg::ADDR_W-1:0]  slot_w_reg, slot_w_next;
    logic [tkst_pkg::KEEP_W-1:0]  fill_count_reg, fill_count_next;
    logic [tkst_pkg::KEEP_W-1:0]  keep_count_reg, keep_count_next;
    logic                         out_valid_reg, out_valid_next;
    tkst_pkg::out_t               out_reg, out_next;
    tkst_pkg::out_t               res_reg, res_next;

    logic signed [tkst_pkg::SCORE_W-1:0] score_reg;
    logic [tkst_pkg::TAG_W-1:0]          tag_reg;

    // slot store and rank list
    logic signed [tkst_pkg::SCORE_W-1:0] slot_score_reg [tkst_pkg::STORE_DEPTH];
    logic [tkst_pkg::TAG_W-1:0]          slot_tag_reg   [tkst_pkg::STORE_DEPTH];
    logic [tkst_pkg::ADDR_W-1:0]         rank_order_reg [tkst_pkg::STORE_DEPTH];

    logic [tkst_pkg::ADDR_W-1:0]         rank_rd_reg;
    logic [tkst_pkg::ADDR_W-1:0]         rank_d_reg;
    logic signed [tkst_pkg::SCORE_W-1:0] score_rd_reg;
    logic [tkst_pkg::TAG_W-1:0]          tag_rd_reg;

    logic                                rank_we;
    logic [tkst_pkg::ADDR_W-1:0]         rank_wdata;
    logic                                slot_we;

    logic                                in_fire;
    logic                                out_free;
    logic [tkst_pkg::KEEP_W-1:0]         keep_eff;
    logic [tkst_pkg::KEEP_W-1:0]         keep_new_eff;
    logic [tkst_pkg::KEEP_W-1:0]         keep_m1;
    logic [tkst_pkg::ADDR_W-1:0]         keep_last;

    logic signed [tkst_pkg::SCORE_W-1:0] cmp_a;
    logic signed [tkst_pkg::SCORE_W-1:0] cmp_b;
    logic                                cmp_lt;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // zero or oversize keep_count means the full store
    assign keep_eff = (keep_count_reg == '0 || keep_count_reg > tkst_pkg::DEPTH_COUNT)
                      ? tkst_pkg::DEPTH_COUNT : keep_count_reg;
    assign keep_new_eff = (cfg_wdata == '0 || cfg_wdata > tkst_pkg::DEPTH_COUNT)
                          ? tkst_pkg::DEPTH_COUNT : cfg_wdata;
    assign keep_m1   = keep_eff - tkst_pkg::KEEP_W'(1);
    assign keep_last = keep_m1[tkst_pkg::ADDR_W-1:0];

    // the one shared signed comparator: new score against the stored one in the walk,
    // stored worst against the new score otherwise
    assign cmp_a  = (state_reg == ST_SHIFT) ? score_reg : score_rd_reg;
    assign cmp_b  = (state_reg == ST_SHIFT) ? score_rd_reg : score_reg;
    assign cmp_lt = (cmp_a < cmp_b);

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        iss_next        = iss_reg;
        slot_w_next     = slot_w_reg;
        fill_count_next = fill_count_reg;
        keep_count_next = keep_count_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        rank_we         = 1'b0;
        rank_wdata      = slot_w_reg;
        slot_we         = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_data.cmd)
                        tkst_pkg::CMD_INSERT:
                        begin
                            if (fill_count_reg < keep_eff)
                            begin
                                slot_w_next     = fill_count_reg[tkst_pkg::ADDR_W-1:0];
                                pos_next        = fill_count_reg[tkst_pkg::ADDR_W-1:0];
                                fill_count_next = fill_count_reg + tkst_pkg::KEEP_W'(1);
                                if (fill_count_reg != '0)
                                begin
                                    iss_next   = fill_count_reg[tkst_pkg::ADDR_W-1:0]
                                                 - tkst_pkg::ADDR_W'(1);
                                    state_next = ST_SHIFT1;
                                end
                                else
                                begin
                                    state_next = ST_PLACE;
                                end
                            end
                            else
                            begin
                                // fetch the worst entry first
                                iss_next   = keep_last;
                                state_next = ST_WORST1;
                            end
                        end
                        tkst_pkg::CMD_READ:
                        begin
                            if ({1'b0, in_data.rank} < fill_count_reg)
                            begin
                                iss_next   = in_data.rank;
                                state_next = ST_READ1;
                            end
                            else
                            begin
                                res_next   = '0;
                                state_next = ST_RESP;
                            end
                        end
                        tkst_pkg::CMD_CLEAR:
                        begin
                            fill_count_next = '0;
                            res_next        = '0;
                            state_next      = ST_RESP;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = ST_RESP;
                        end
                    endcase
                end
                if (cfg_we)
                begin
                    keep_count_next = cfg_wdata;
                    // drop the worst entries beyond the new count
                    if (fill_count_reg > keep_new_eff)
                    begin
                        fill_count_next = keep_new_eff;
                    end
                end
            end
            ST_WORST1:
            begin
                state_next = ST_WORST2;
            end
            ST_WORST2:
            begin
                state_next = ST_WORST_CMP;
            end
            ST_WORST_CMP:
            begin
                if (cmp_lt)
                begin
                    res_next   = '0;
                    state_next = ST_RESP;
                end
                else
                begin
                    // reuse the worst entry's slot
                    slot_w_next = rank_d_reg;
                    pos_next    = keep_last;
                    if (keep_last != '0)
                    begin
                        iss_next   = keep_last - tkst_pkg::ADDR_W'(1);
                        state_next = ST_SHIFT1;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
            end
            ST_SHIFT1:
            begin
                iss_next   = iss_reg - tkst_pkg::ADDR_W'(1);
                state_next = ST_SHIFT2;
            end
            ST_SHIFT2:
            begin
                iss_next   = iss_reg - tkst_pkg::ADDR_W'(1);
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                iss_next = iss_reg - tkst_pkg::ADDR_W'(1);
                if (cmp_lt)
                begin
                    // move the worse entry down one rank
                    rank_we    = 1'b1;
                    rank_wdata = rank_d_reg;
                    pos_next   = pos_reg - tkst_pkg::ADDR_W'(1);
                    if (pos_reg == tkst_pkg::ADDR_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                rank_we              = 1'b1;
                rank_wdata           = slot_w_reg;
                slot_we              = 1'b1;
                res_next             = '0;
                res_next.accepted    = 1'b1;
                res_next.slot        = slot_w_reg;
                res_next.position    = pos_reg;
                state_next           = ST_RESP;
            end
            ST_READ1:
            begin
                state_next = ST_READ2;
            end
            ST_READ2:
            begin
                state_next = ST_READ_OUT;
            end
            ST_READ_OUT:
            begin
                res_next             = '0;
                res_next.slot        = rank_d_reg;
                res_next.out_score   = score_rd_reg;
                res_next.out_tag     = tag_rd_reg;
                res_next.entry_valid = 1'b1;
                state_next           = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            iss_reg        <= '0;
            slot_w_reg     <= '0;
            fill_count_reg <= '0;
            keep_count_reg <= tkst_pkg::DEPTH_COUNT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            iss_reg        <= iss_next;
            slot_w_reg     <= slot_w_next;
            fill_count_reg <= fill_count_next;
            keep_count_reg <= keep_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            score_reg <= in_data.score;
            tag_reg   <= in_data.tag;
        end
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // rank list: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_order_reg[pos_reg] <= rank_wdata;
        end
        rank_rd_reg <= rank_order_reg[iss_reg];
        rank_d_reg  <= rank_rd_reg;
    end

    // slot store, read at the slot the rank list just returned
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_score_reg[slot_w_reg] <= score_reg;
            slot_tag_reg[slot_w_reg]   <= tag_reg;
        end
        score_rd_reg <= slot_score_reg[rank_rd_reg];
        tag_rd_reg   <= slot_tag_reg[rank_rd_reg];
    end

    `TKST_ASSERT_ALWAYS(a_fill_in_range, fill_count_reg <= keep_eff,
                        "fill count above keep count")
    `TKST_ASSERT_ALWAYS(a_shift_pos, (state_reg != ST_SHIFT) || (pos_reg != '0),
                        "rank walk past best")
    `TKST_ASSERT_NEXT(a_fill_step,
                      in_fire && !cfg_we && (in_data.cmd == tkst_pkg::CMD_INSERT)
                          && (fill_count_reg < keep_eff),
                      fill_count_reg == $past(fill_count_reg) + tkst_pkg::KEEP_W'(1),
                      "fill count did not advance")

endmodule

FILE: tb/topk_result_checker.sv
// Result checker for the top-k tracker: mirrors the slot and rank stores and compares each result.
`timescale 1ns / 100ps

module topk_result_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  tkst_pkg::in_t               in_data,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  tkst_pkg::out_t              out_data,
    input  logic                        cfg_we,
    input  logic [tkst_pkg::KEEP_W-1:0] cfg_wdata,
    output int                          fail_count,
    output int                          awaited_count
);
    import tkst_pkg::*;

    logic signed [SCORE_W-1:0] slot_score [STORE_DEPTH];
    logic [TAG_W-1:0]          slot_tag   [STORE_DEPTH];
    logic [ADDR_W-1:0]         rank_list  [STORE_DEPTH];
    int unsigned               fill;
    logic [KEEP_W-1:0]         keep_reg;
    out_t                      awaited_results [$];
    int                        errors;

    // Out-of-range settings behave as the full store depth.
    function automatic int unsigned keep_limit();
        if (keep_reg == '0 || keep_reg > DEPTH_COUNT)
            return STORE_DEPTH;
        return keep_reg;
    endfunction

    // Update the mirrored list for one command and return the result it should give.
    function automatic out_t rank_update(input in_t item);
        out_t              r;
        int unsigned       limit;
        int unsigned       pos;
        logic [ADDR_W-1:0] slot_no;
        r = '0;
        limit = keep_limit();
        case (item.cmd)
            CMD_INSERT:
            begin
                if (fill < limit)
                begin
                    pos = fill;
                    slot_no = ADDR_W'(fill);
                    fill++;
                end
                else
                begin
                    slot_no = rank_list[limit - 1];
                    // Reject anything worse than the current worst; a tie replaces it.
                    if ($signed(slot_score[slot_no]) < $signed(item.score))
                        return r;
                    pos = limit - 1;
                end
                while (pos >= 1 && $signed(item.score) < $signed(slot_score[rank_list[pos - 1]]))
                begin
                    rank_list[pos] = rank_list[pos - 1];
                    pos--;
                end
                rank_list[pos] = slot_no;
                slot_score[slot_no] = item.score;
                slot_tag[slot_no] = item.tag;
                r.accepted = 1'b1;
                r.slot = slot_no;
                r.position = ADDR_W'(pos);
            end
            CMD_READ:
            begin
                if (item.rank < fill)
                begin
                    r.slot = rank_list[item.rank];
                    r.out_score = slot_score[r.slot];
                    r.out_tag = slot_tag[r.slot];
                    r.entry_valid = 1'b1;
                end
            end
            CMD_CLEAR:
                fill = 0;
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_t want;
        if (!rst_n)
        begin
            fill = 0;
            keep_reg = DEPTH_COUNT;
            awaited_results.delete();
            errors = 0;
            fail_count <= 0;
            awaited_count <= 0;
        end
        else
        begin
            // Compare before taking the new command so a stray result is never masked.
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("accepted", want.accepted, out_data.accepted);
                    check_field("slot", want.slot, out_data.slot);
                    check_field("position", want.position, out_data.position);
                    check_field("out_score", want.out_score, out_data.out_score);
                    check_field("out_tag", want.out_tag, out_data.out_tag);
                    check_field("entry_valid", want.entry_valid, out_data.entry_valid);
                end
            end
            if (cfg_we)
            begin
                keep_reg = cfg_wdata;
                // Lowering the count drops the worst entries.
                if (fill > keep_limit())
                    fill = keep_limit();
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(rank_update(in_data));
            fail_count <= errors;
            awaited_count <= awaited_results.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Testbench top for the top-k tracker: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import tkst_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         PHASES          = 9;
    localparam int         ITEMS_PER_PHASE = 62;
    localparam int         DRAIN_CYCLES    = 16;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_t               in_data;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_t              out_data;
    logic              cfg_we;
    logic [KEEP_W-1:0] cfg_wdata;

    int fail_count;
    int awaited_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int commands_sent  = 0;
    int keep_writes    = 0;

    // Include the zero and above-depth settings, which act as the full depth.
    logic [KEEP_W-1:0] phase_keep [PHASES] = '{
        11'd3, 11'd1, 11'd2047, 11'd40, 11'd8, 11'd1024, 11'd0, 11'd2, 11'd1025
    };

    top_k_smallest_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    topk_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .awaited_count (awaited_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    function automatic in_t cmd_item(input logic [1:0] cmd, input logic signed [SCORE_W-1:0] score,
                                     input logic [TAG_W-1:0] tag, input logic [ADDR_W-1:0] rank);
        in_t c;
        c.cmd = cmd;
        c.score = score;
        c.tag = tag;
        c.rank = rank;
        return c;
    endfunction

    function automatic logic signed [SCORE_W-1:0] random_score();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            case ($urandom_range(3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0;
                default: return -32'sh1;
            endcase
        end
        // Narrow range forces plenty of ties.
        if (pick < 5)
            return int'($urandom_range(31)) - 16;
        return $urandom;
    endfunction

    function automatic in_t random_command(input int unsigned keep_eff);
        in_t         c;
        int unsigned pick;
        int unsigned top_rank;
        pick = $urandom_range(99);
        top_rank = (keep_eff < 1023) ? keep_eff + 1 : 1023;
        c.score = random_score();
        c.tag = $urandom;
        c.rank = ADDR_W'($urandom);
        if (pick < 60)
            c.cmd = CMD_INSERT;
        else if (pick < 92)
        begin
            c.cmd = CMD_READ;
            if ($urandom_range(3) != 0)
                c.rank = ADDR_W'($urandom_range(top_rank));
        end
        else if (pick < 96)
            c.cmd = CMD_CLEAR;
        else
            c.cmd = CMD_UNUSED;
        return c;
    endfunction

    // Hold valid high across back-to-back commands; drop it only in a gap.
    task automatic send_command(input in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        commands_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        keep_writes++;
    endtask

    initial
    begin : stimulus
        int unsigned keep_eff;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, unknown command with every bit set, clear of an empty list.
        send_command(cmd_item(CMD_READ, 0, 0, 0));
        send_command(cmd_item(CMD_UNUSED, -1, 32'hFFFF_FFFF, 10'h3FF));
        send_command(cmd_item(CMD_CLEAR, 0, 0, 0));
        // Score and tag extremes, then a tie that must rank after the earlier arrival.
        send_command(cmd_item(CMD_INSERT, 32'sh0, 32'h0, 0));
        send_command(cmd_item(CMD_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 0));
        send_command(cmd_item(CMD_INSERT, 32'sh8000_0000, 32'h1234_5678, 0));
        send_command(cmd_item(CMD_INSERT, -32'sh1, 32'hA5A5_A5A5, 0));
        send_command(cmd_item(CMD_INSERT, 32'sh0, 32'h1, 0));
        send_command(cmd_item(CMD_INSERT, 32'sh1, 32'h2, 0));
        send_command(cmd_item(CMD_READ, 0, 0, 0));
        send_command(cmd_item(CMD_READ, 0, 0, 2));
        send_command(cmd_item(CMD_READ, 0, 0, 5));
        send_command(cmd_item(CMD_READ, 0, 0, 6));
        send_command(cmd_item(CMD_READ, 0, 0, 10'h3FF));
        // Shrink below the fill, then worse, equal-to-worst and better inserts.
        write_keep(11'd4);
        send_command(cmd_item(CMD_INSERT, 32'sh7FFF_FFFF, 32'h0, 0));
        send_command(cmd_item(CMD_INSERT, 32'sh0, 32'h3, 0));
        send_command(cmd_item(CMD_INSERT, 32'sh8000_0000, 32'h4, 0));
        send_command(cmd_item(CMD_READ, 0, 0, 3));
        write_keep(11'd1);
        send_command(cmd_item(CMD_INSERT, -32'sh5, 32'h5, 0));
        send_command(cmd_item(CMD_READ, 0, 0, 0));
        send_command(cmd_item(CMD_READ, 0, 0, 1));
        send_command(cmd_item(CMD_CLEAR, 0, 0, 0));
        send_command(cmd_item(CMD_READ, 0, 0, 0));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_keep(phase_keep[phase]);
            if (phase < 3)
            begin
                send_idle_pct = 35;
                recv_stall_pct <= 65;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 65;
                recv_stall_pct <= 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            keep_eff = (phase_keep[phase] == '0 || phase_keep[phase] > DEPTH_COUNT)
                       ? STORE_DEPTH : phase_keep[phase];
            repeat (ITEMS_PER_PHASE)
                send_command(random_command(keep_eff));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d commands over %0d keep_count writes (1, 1024, 0 and above depth)",
                 commands_sent, keep_writes);
        $display("tb: sender/receiver idling 35/65, then 65/35, then none");
        if (fail_count == 0 && awaited_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
